>>> rtl/core/blir_pkg.sv
package blir_pkg;

  // Sample and phase formats
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int STEP_BITS   = FRAC_BITS + 2;
  localparam int ACC_BITS    = FRAC_BITS + 18;
  localparam int POS_BITS    = 16;
  localparam int CFG_BITS    = STEP_BITS;
  localparam int PROD_BITS   = SAMPLE_BITS + FRAC_BITS + 2;

  // Register reset values
  localparam logic [STEP_BITS-1:0] STEP_RESET          = STEP_BITS'(67200);
  localparam logic [POS_BITS-1:0]  BLOCK_INPUTS_RESET  = POS_BITS'(2100);
  localparam logic [POS_BITS-1:0]  BLOCK_OUTPUTS_RESET = POS_BITS'(2048);

  // A step of exactly 1.0
  localparam logic [STEP_BITS-1:0] STEP_ONE = STEP_BITS'(1) << FRAC_BITS;

  // Rounding constant: one half LSB of the result
  localparam logic [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1) << (FRAC_BITS - 1);

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_STEP_RATIO    = 2'd0,
    REG_BLOCK_INPUTS  = 2'd1,
    REG_BLOCK_OUTPUTS = 2'd2
  } cfg_reg_t;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // prev + frac*(cur - prev), rounded half up at FRAC_BITS fraction bits.
  // The result lies between prev and cur, so the low bits are exact.
  function automatic sample_t interp(input sample_t prev, input sample_t cur,
                                     input logic [FRAC_BITS-1:0] frac);
    logic signed [SAMPLE_BITS:0]  diff;
    logic signed [PROD_BITS-1:0]  prod;
    logic signed [PROD_BITS-1:0]  base;
    logic signed [PROD_BITS-1:0]  acc;
    diff = $signed({cur[SAMPLE_BITS-1], cur}) - $signed({prev[SAMPLE_BITS-1], prev});
    prod = diff * $signed({1'b0, frac});
    base = $signed({{2{prev[SAMPLE_BITS-1]}}, prev, {FRAC_BITS{1'b0}}});
    acc  = base + prod + $signed(ROUND_HALF);
    return acc[SAMPLE_BITS+FRAC_BITS-1:FRAC_BITS];
  endfunction

endpackage

>>> rtl/core/block_linear_interp_resampler_core.sv
// Block linear-interpolation resampler for complex I/Q samples.
//
// Input channel (in_valid / in_stall, sample_i, sample_q): one I/Q sample per
// beat, at the receiver rate. Output channel (out_valid / out_stall, out_i,
// out_q, block_end): zero or one interpolated sample per input beat, at the
// input scale. Output j of a block sits at input position j*step_eff; it is
// emitted when the sample after its integer part arrives. block_end marks the
// last output of a block. The sample with index block_inputs starts the next.
//
// A result is registered in the cycle after its input beat. One input beat is
// taken per cycle while the output is not stalled. The interpolation
// multiply-add and the phase update are registered with the input beat.
//
// The user is to write configuration (cfg_write, cfg_index, cfg_data) only
// while idle; the block does not enforce it. Reset restores the register
// defaults, clears the block position and phase, and empties the output
// register. The first sample after reset only becomes sample 0 of a block.
// A stalled result raises in_stall in that cycle and holds until it is taken.
module block_linear_interp_resampler_core (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_write,
  input  logic [1:0]                          cfg_index,
  input  logic [blir_pkg::CFG_BITS-1:0]       cfg_data,
  // input samples
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [blir_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic signed [blir_pkg::SAMPLE_BITS-1:0] sample_q,
  // interpolated samples
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [blir_pkg::SAMPLE_BITS-1:0] out_i,
  output logic signed [blir_pkg::SAMPLE_BITS-1:0] out_q,
  output logic                                block_end
);

  localparam int F = blir_pkg::FRAC_BITS;
  localparam int A = blir_pkg::ACC_BITS;
  localparam int P = blir_pkg::POS_BITS;

  // configuration registers
  logic [blir_pkg::STEP_BITS-1:0] step_ratio;
  logic [P-1:0]                   block_inputs;
  logic [P-1:0]                   block_outputs;

  // block state
  blir_pkg::sample_t prev_i;
  blir_pkg::sample_t prev_q;
  logic [P-1:0]      in_position;
  logic [P-1:0]      out_position;
  logic [A-1:0]      phase_acc;

  logic                           accept;
  logic [blir_pkg::STEP_BITS-1:0] step_eff;
  logic [A-1:0]                   phase_next;
  logic [A-F-1:0]                 phase_int;
  logic [P-1:0]                   in_pos_prev;
  logic                           first;
  logic                           emit;
  logic                           last;
  logic                           block_done;

  // beat is taken whenever the output register is free or draining
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // per-sample decisions
  always_comb begin
    step_eff    = (step_ratio < blir_pkg::STEP_ONE) ? blir_pkg::STEP_ONE : step_ratio;
    phase_next  = phase_acc + A'(step_eff);
    phase_int   = phase_acc[A-1:F];
    in_pos_prev = in_position - P'(1);
    first       = (in_position == '0);
    emit        = !first && (out_position < block_outputs) &&
                  (phase_int == (A-F)'(in_pos_prev));
    last        = ((P+1)'(out_position) + (P+1)'(1) >= (P+1)'(block_outputs)) ||
                  (phase_next[A-1:F] >= (A-F)'(block_inputs));
    block_done  = (in_position >= block_inputs);
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      step_ratio    <= blir_pkg::STEP_RESET;
      block_inputs  <= blir_pkg::BLOCK_INPUTS_RESET;
      block_outputs <= blir_pkg::BLOCK_OUTPUTS_RESET;
    end else if (cfg_write) begin
      case (blir_pkg::cfg_reg_t'(cfg_index))
        blir_pkg::REG_STEP_RATIO:    step_ratio    <= cfg_data;
        blir_pkg::REG_BLOCK_INPUTS:  block_inputs  <= cfg_data[P-1:0];
        blir_pkg::REG_BLOCK_OUTPUTS: block_outputs <= cfg_data[P-1:0];
        default: ;
      endcase
    end
  end

  // block position and phase
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_i       <= '0;
      prev_q       <= '0;
      in_position  <= '0;
      out_position <= '0;
      phase_acc    <= '0;
    end else if (accept) begin
      prev_i <= sample_i;
      prev_q <= sample_q;
      if (first) begin
        in_position <= P'(1);
      end else begin
        if (emit) begin
          out_position <= out_position + P'(1);
          phase_acc    <= phase_next;
        end
        if (block_done) begin
          in_position  <= P'(1);
          out_position <= '0;
          phase_acc    <= '0;
        end else begin
          in_position <= in_position + P'(1);
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_i     <= blir_pkg::interp(prev_i, sample_i, phase_acc[F-1:0]);
      out_q     <= blir_pkg::interp(prev_q, sample_q, phase_acc[F-1:0]);
      block_end <= last;
    end
  end

endmodule

>>> rtl/core/blir_checker.sv
module blir_checker (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    in_valid,
  input logic                                    in_stall,
  input logic signed [blir_pkg::SAMPLE_BITS-1:0] sample_i,
  input logic signed [blir_pkg::SAMPLE_BITS-1:0] sample_q,
  input logic                                    out_valid,
  input logic                                    out_stall,
  input logic signed [blir_pkg::SAMPLE_BITS-1:0] out_i,
  input logic signed [blir_pkg::SAMPLE_BITS-1:0] out_q,
  input logic                                    block_end
);

  // input is held back only by a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall raised without a stalled result");

  // output register is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result present after reset");

  // every new result comes from an input beat in the previous cycle
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !($past(out_valid) && $past(out_stall)))
      |-> $past(in_valid && !in_stall))
    else $error("result without a preceding input beat");

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_i) && $stable(out_q) && $stable(block_end)))
    else $error("stalled result changed");

endmodule

bind block_linear_interp_resampler_core blir_checker u_blir_checker (.*);

>>> bench/blir_resample_checker.sv
`timescale 1ns / 1ps

module blir_resample_checker
  import blir_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data,
  input  logic                in_valid,
  input  logic                in_stall,
  input  sample_t             sample_i,
  input  sample_t             sample_q,
  input  logic                out_valid,
  input  logic                out_stall,
  input  sample_t             out_i,
  input  sample_t             out_q,
  input  logic                block_end,
  output int                  fail_count,
  output int                  pending
);

  typedef struct packed {
    sample_t i;
    sample_t q;
    logic    last;
  } resampled_t;

  // Register shadows
  logic [STEP_BITS-1:0] step_ratio_r;
  logic [POS_BITS-1:0]  block_inputs_r;
  logic [POS_BITS-1:0]  block_outputs_r;

  // Resampler state
  sample_t              prev_i;
  sample_t              prev_q;
  logic [POS_BITS-1:0]  in_pos;
  logic [POS_BITS-1:0]  out_pos;
  logic [ACC_BITS-1:0]  phase;

  resampled_t expected_outs[$];
  int         errors = 0;

  // (1-frac)*a + frac*b, rounded half up at FRAC_BITS fraction bits
  function automatic sample_t interp_sample(input sample_t a, input sample_t b,
                                            input logic [FRAC_BITS-1:0] frac);
    longint acc;
    acc = (longint'(a) <<< FRAC_BITS) + longint'(frac) * (longint'(b) - longint'(a))
          + (longint'(1) <<< (FRAC_BITS - 1));
    return sample_t'(acc >>> FRAC_BITS);
  endfunction

  // One accepted input beat: advance the block and queue any output it causes
  function automatic void predict_beat(input sample_t si, input sample_t sq);
    logic [STEP_BITS-1:0] eff_step;
    longint unsigned      next_phase;
    resampled_t           r;
    if (in_pos == '0) begin
      // first sample after reset only becomes sample 0
      prev_i = si;
      prev_q = sq;
      in_pos = POS_BITS'(1);
      return;
    end
    eff_step = (step_ratio_r < STEP_ONE) ? STEP_ONE : step_ratio_r;
    if (out_pos < block_outputs_r &&
        64'(phase >> FRAC_BITS) == 64'(in_pos) - 64'd1) begin
      next_phase = 64'(phase) + 64'(eff_step);
      r.i    = interp_sample(prev_i, si, phase[FRAC_BITS-1:0]);
      r.q    = interp_sample(prev_q, sq, phase[FRAC_BITS-1:0]);
      r.last = (64'(out_pos) + 64'd1 >= 64'(block_outputs_r)) ||
               ((next_phase >> FRAC_BITS) >= 64'(block_inputs_r));
      expected_outs.push_back(r);
      out_pos = out_pos + POS_BITS'(1);
      phase   = next_phase[ACC_BITS-1:0];
    end
    // the sample at index block_inputs opens the next block
    if (in_pos >= block_inputs_r) begin
      in_pos  = POS_BITS'(1);
      out_pos = '0;
      phase   = '0;
    end else begin
      in_pos = in_pos + POS_BITS'(1);
    end
    prev_i = si;
    prev_q = sq;
  endfunction

  always @(posedge clk) begin
    resampled_t want;
    if (rst) begin
      step_ratio_r    = STEP_RESET;
      block_inputs_r  = BLOCK_INPUTS_RESET;
      block_outputs_r = BLOCK_OUTPUTS_RESET;
      prev_i  = '0;
      prev_q  = '0;
      in_pos  = '0;
      out_pos = '0;
      phase   = '0;
      expected_outs.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_STEP_RATIO:    step_ratio_r    = cfg_data[STEP_BITS-1:0];
          REG_BLOCK_INPUTS:  block_inputs_r  = cfg_data[POS_BITS-1:0];
          REG_BLOCK_OUTPUTS: block_outputs_r = cfg_data[POS_BITS-1:0];
          default: ;
        endcase
      end
      // output beat against the oldest expectation
      if (out_valid && !out_stall) begin
        if (expected_outs.size() == 0) begin
          $display("%0t: output beat with nothing expected: i=%0d q=%0d block_end=%0b",
                   $time, out_i, out_q, block_end);
          errors++;
        end else begin
          want = expected_outs.pop_front();
          if (out_i !== want.i) begin
            $display("%0t: out_i expected %0d got %0d", $time, want.i, out_i);
            errors++;
          end
          if (out_q !== want.q) begin
            $display("%0t: out_q expected %0d got %0d", $time, want.q, out_q);
            errors++;
          end
          if (block_end !== want.last) begin
            $display("%0t: block_end expected %0b got %0b", $time, want.last, block_end);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall)
        predict_beat(sample_i, sample_q);
    end
    fail_count <= errors;
    pending    <= expected_outs.size();
  end

endmodule

>>> bench/tb_block_linear_interp_resampler_core.sv
`timescale 1ns / 1ps

module tb_block_linear_interp_resampler_core;
  import blir_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int HOLD_CYCLES   = 600;
  localparam int SETTLE_CYCLES = 4;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                cfg_write = 1'b0;
  cfg_reg_t            cfg_index = REG_STEP_RATIO;
  logic [CFG_BITS-1:0] cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  sample_t             sample_i  = '0;
  sample_t             sample_q  = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  sample_t             out_i;
  sample_t             out_q;
  logic                block_end;

  int   fail_count;
  int   pending;
  int   send_idle = 0;
  int   stall_pct = 0;
  logic long_hold = 1'b0;
  int   hold_cnt  = 0;
  int   cycles    = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  block_linear_interp_resampler_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample_i  (sample_i),
    .sample_q  (sample_q),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_i     (out_i),
    .out_q     (out_q),
    .block_end (block_end)
  );

  blir_resample_checker i_chk (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample_i   (sample_i),
    .sample_q   (sample_q),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_i      (out_i),
    .out_q      (out_q),
    .block_end  (block_end),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("block_linear_interp_resampler_core regression: fail");
      $finish;
    end
  end

  // Receiver: one long hold-off when asked, random stalls otherwise
  always @(posedge clk) begin
    if (long_hold && hold_cnt < HOLD_CYCLES) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt + 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Mostly full-range noise, with the rails and small values near zero showing up often
  function automatic sample_t pick_sample();
    case ($urandom_range(7))
      0:       return sample_t'(32767);
      1:       return sample_t'(-32768);
      2:       return sample_t'($urandom_range(0, 15)) - sample_t'(8);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic send_sample(input sample_t si, input sample_t sq);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_i <= si;
    sample_q <= sq;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // Stop sending and wait for every expected beat to drain
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle = send_pct;
    stall_pct <= recv_pct;
  endtask

  task automatic run_phase(input logic [CFG_BITS-1:0] step, input logic [CFG_BITS-1:0] n_in,
                           input logic [CFG_BITS-1:0] n_out, input int n_items);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= REG_STEP_RATIO;
    cfg_data  <= step;
    @(posedge clk);
    cfg_index <= REG_BLOCK_INPUTS;
    cfg_data  <= n_in;
    @(posedge clk);
    cfg_index <= REG_BLOCK_OUTPUTS;
    cfg_data  <= n_out;
    @(posedge clk);
    cfg_write <= 1'b0;
    repeat (n_items) send_sample(pick_sample(), pick_sample());
  endtask

  initial begin
    int k;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: rails and full swings under the reset settings;
    // the first beat only seeds sample 0
    send_sample(sample_t'(0), sample_t'(0));
    send_sample(sample_t'(32767), sample_t'(-32768));
    send_sample(sample_t'(-32768), sample_t'(32767));
    send_sample(sample_t'(32767), sample_t'(32767));
    send_sample(sample_t'(-32768), sample_t'(-32768));
    send_sample(sample_t'(-1), sample_t'(1));
    send_sample(sample_t'(1), sample_t'(-1));
    send_sample(sample_t'(16'h5555), sample_t'(16'hAAAA));
    // step below one, block of a single input
    run_phase(18'd0, 18'd1, 18'd5, 3);
    // large step, outputs run past the block end
    run_phase(18'h3FFFF, 18'd4, 18'd65535, 5);
    // no outputs per block
    run_phase(18'd65536, 18'd10, 18'd0, 3);
    // block end pulled below the current position
    run_phase(18'd98304, 18'd2, 18'd2, 4);
    // output count reached well before the block ends
    run_phase(18'd65536, 18'd20, 18'd3, 6);

    // Random: no idling, receiver holds off long enough to back up the input;
    // short blocks so that outputs start within a few beats
    set_idle(0, 0);
    long_hold <= 1'b1;
    run_phase(18'd65536, 18'd16, 18'd65535, 200);
    set_idle(88, 0);
    run_phase(18'd131072, 18'd2, 18'd1, 150);
    set_idle(0, 88);
    run_phase(18'd67200, 18'd150, 18'd140, 200);
    set_idle(12, 12);
    run_phase(CFG_BITS'($urandom_range(65536, 131072)), CFG_BITS'($urandom_range(2, 40)),
              CFG_BITS'($urandom_range(1, 40)), 300);
    // short phases with any step ratio the field allows and block sizes up to 48
    for (k = 0; k < 6; k++) begin
      case (k % 4)
        0:       set_idle(0, 0);
        1:       set_idle(88, 0);
        2:       set_idle(0, 88);
        default: set_idle(12, 12);
      endcase
      run_phase(CFG_BITS'($urandom_range(0, 262143)), CFG_BITS'($urandom_range(0, 48)),
                CFG_BITS'($urandom_range(0, 48)), 50);
    end

    settle();
    if (fail_count == 0) begin
      $display("block_linear_interp_resampler_core regression: pass");
    end else begin
      $display("block_linear_interp_resampler_core regression: fail");
    end
    $finish;
  end

endmodule
